FILE: sv/all_pairs_shortest_path_top_assert.svh
// Assertion helpers shared by the block's modules.
// Both macros expect clk_i and rst_ni to be visible in the module.
`ifndef ALL_PAIRS_SHORTEST_PATH_TOP_ASSERT_SVH
`define ALL_PAIRS_SHORTEST_PATH_TOP_ASSERT_SVH

// Same-cycle implication.
`define APSP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define APSP_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/apsp_pkg.sv
package apsp_pkg;

  localparam int MAX_VERTICES = 16;
  localparam int MAX_EDGES    = 64;
  localparam int WEIGHT_BITS  = 16;

  localparam int VW     = $clog2(MAX_VERTICES);
  localparam int VCW    = $clog2(MAX_VERTICES + 1);
  localparam int EAW    = $clog2(MAX_EDGES);
  localparam int ECW    = $clog2(MAX_EDGES + 1);
  localparam int PW     = 32;
  localparam int DW     = 40;
  localparam int EDGE_W = 8 + WEIGHT_BITS;
  localparam int DIST_W = 33;

  localparam logic signed [DW-1:0] SAT_HI = DW'(2147483647);
  localparam logic signed [DW-1:0] SAT_LO = ~SAT_HI;

  typedef enum logic [1:0] {
    OP_ADD     = 2'd0,
    OP_COMPUTE = 2'd1,
    OP_QUERY   = 2'd2,
    OP_CLEAR   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NEG_CYCLE = 2'd2,
    ST_NOT_READY = 2'd3
  } status_e;

  typedef struct packed {
    op_e         op;
    logic [3:0]  src;
    logic [3:0]  dst;
    logic [15:0] weight;
  } cmd_t;

  typedef struct packed {
    status_e     status;
    logic [31:0] distance;
    logic        reachable;
  } res_t;

  function automatic logic in_range(input logic [3:0] x, input logic [VCW-1:0] vc);
    return 32'(x) < 32'(vc);
  endfunction

  function automatic logic [31:0] sat32(input logic signed [DW-1:0] v);
    logic signed [DW-1:0] r;
    r = v;
    if (v > SAT_HI) r = SAT_HI;
    if (v < SAT_LO) r = SAT_LO;
    return r[31:0];
  endfunction

endpackage

FILE: sv/apsp_ram.sv
module apsp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

FILE: sv/apsp_core.sv
`include "all_pairs_shortest_path_top_assert.svh"

module apsp_core import apsp_pkg::*; (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cmd_valid_i,
  input  cmd_t           cmd_i,
  input  logic [VCW-1:0] vc_i,
  input  logic           cfg_we_i,
  output logic           ready_o,
  output logic           res_valid_o,
  output res_t           res_o
);

  typedef enum logic [4:0] {
    S_IDLE, S_QRY, S_PINIT,
    S_BF_RD, S_BF_E, S_BF_PS, S_BF_PD,
    S_DJ_INIT, S_DJ_PS, S_SEL_RD, S_SEL_CMP, S_SEL_END, S_DJ_PB,
    S_RX_RD, S_RX_E, S_RX_PT, S_RX_CMP,
    S_FN_RD, S_FN_A, S_FN_B, S_FN_W
  } state_e;

  state_e state_q;
  logic [ECW-1:0] edge_cnt_q, e_q;
  logic [VCW-1:0] it_q, v_q, s_q;
  logic cycle_q, valid_q, chk_q, found_q;
  logic [MAX_VERTICES-1:0] seen_q, vis_q;
  logic [VW-1:0] best_q, edst_q;
  logic [WEIGHT_BITS-1:0] ew_q;
  logic signed [DW-1:0] acc_q, bestd_q, dbp_q, pots_q;
  logic res_valid_q;
  res_t res_q;

  // Memory ports.
  logic edge_we, pot_we, d_we, dist_we;
  logic [EAW-1:0] edge_waddr, edge_raddr;
  logic [EDGE_W-1:0] edge_wdata, edge_rd;
  logic [VW-1:0] pot_waddr, pot_raddr, d_waddr, d_raddr;
  logic [PW-1:0] pot_wdata, pot_rd;
  logic [DW-1:0] d_wdata, d_rd;
  logic [2*VW-1:0] dist_waddr, dist_raddr;
  logic [DIST_W-1:0] dist_wdata, dist_rd;

  // Shared adder and comparator.
  logic signed [DW-1:0] add_a, add_b, sum, cmp_a, cmp_b, pot_x, d_x;
  logic add_sub, lt;

  logic [3:0] er_src, er_dst;
  logic [WEIGHT_BITS-1:0] er_w;
  logic er_use;
  logic [VW-1:0] v_idx, s_idx;

  assign er_w   = edge_rd[WEIGHT_BITS-1:0];
  assign er_dst = edge_rd[WEIGHT_BITS +: 4];
  assign er_src = edge_rd[WEIGHT_BITS+4 +: 4];
  assign er_use = in_range(er_src, vc_i) && in_range(er_dst, vc_i);
  assign pot_x  = DW'($signed(pot_rd));
  assign d_x    = $signed(d_rd);
  assign v_idx  = v_q[VW-1:0];
  assign s_idx  = s_q[VW-1:0];

  always_comb begin
    add_a = acc_q;
    add_b = pot_x;
    add_sub = 1'b0;
    cmp_a = acc_q;
    cmp_b = pot_x;
    case (state_q)
      S_BF_PS:   begin add_a = pot_x; add_b = DW'($signed(ew_q)); end
      S_RX_E:    begin add_a = dbp_q; add_b = DW'($signed(er_w)); end
      S_RX_PT:   begin add_a = acc_q; add_b = pot_x; add_sub = 1'b1; end
      S_DJ_PB:   begin add_a = bestd_q; add_b = pot_x; end
      S_FN_A:    begin add_a = d_x; add_b = pot_x; end
      S_FN_B:    begin add_a = acc_q; add_b = pots_q; add_sub = 1'b1; end
      S_SEL_CMP: begin cmp_a = d_x; cmp_b = bestd_q; end
      S_RX_CMP:  begin cmp_a = acc_q; cmp_b = d_x; end
      default: ;
    endcase
    sum = add_sub ? add_a - add_b : add_a + add_b;
    lt  = cmp_a < cmp_b;
  end

  always_comb begin
    edge_we = 1'b0;  edge_waddr = edge_cnt_q[EAW-1:0];
    edge_wdata = {cmd_i.src, cmd_i.dst, WEIGHT_BITS'(cmd_i.weight)};
    edge_raddr = e_q[EAW-1:0];
    pot_we = 1'b0;  pot_waddr = edst_q;  pot_wdata = acc_q[PW-1:0];  pot_raddr = '0;
    d_we = 1'b0;  d_waddr = edst_q;  d_wdata = acc_q;  d_raddr = '0;
    dist_we = 1'b0;  dist_waddr = {s_idx, v_idx};
    dist_wdata = {seen_q[v_idx], seen_q[v_idx] ? sat32(acc_q) : 32'd0};
    dist_raddr = {VW'(cmd_i.src), VW'(cmd_i.dst)};
    case (state_q)
      S_IDLE: edge_we = cmd_valid_i && cmd_i.op == OP_ADD
                        && edge_cnt_q != ECW'(MAX_EDGES);
      S_PINIT: begin pot_we = 1'b1; pot_waddr = v_idx; pot_wdata = '0; end
      S_BF_E:  pot_raddr = VW'(er_src);
      S_BF_PS: pot_raddr = edst_q;
      S_BF_PD: pot_we = lt && !chk_q;
      S_DJ_INIT: begin d_we = 1'b1; d_waddr = s_idx; d_wdata = '0; pot_raddr = s_idx; end
      S_SEL_RD:  d_raddr = v_idx;
      S_SEL_END: pot_raddr = best_q;
      S_RX_E:    pot_raddr = VW'(er_dst);
      S_RX_PT:   d_raddr = edst_q;
      S_RX_CMP:  d_we = !seen_q[edst_q] || lt;
      S_FN_RD:   begin d_raddr = v_idx; pot_raddr = v_idx; end
      S_FN_W:    dist_we = 1'b1;
      default: ;
    endcase
  end

  apsp_ram #(.WIDTH(EDGE_W), .DEPTH(MAX_EDGES)) u_edge_ram (
    .clk_i, .we_i(edge_we), .waddr_i(edge_waddr), .wdata_i(edge_wdata),
    .raddr_i(edge_raddr), .rdata_o(edge_rd));

  apsp_ram #(.WIDTH(PW), .DEPTH(MAX_VERTICES)) u_pot_ram (
    .clk_i, .we_i(pot_we), .waddr_i(pot_waddr), .wdata_i(pot_wdata),
    .raddr_i(pot_raddr), .rdata_o(pot_rd));

  apsp_ram #(.WIDTH(DW), .DEPTH(MAX_VERTICES)) u_d_ram (
    .clk_i, .we_i(d_we), .waddr_i(d_waddr), .wdata_i(d_wdata),
    .raddr_i(d_raddr), .rdata_o(d_rd));

  apsp_ram #(.WIDTH(DIST_W), .DEPTH(2**(2*VW))) u_dist_ram (
    .clk_i, .we_i(dist_we), .waddr_i(dist_waddr), .wdata_i(dist_wdata),
    .raddr_i(dist_raddr), .rdata_o(dist_rd));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      edge_cnt_q  <= '0;
      cycle_q     <= 1'b0;
      valid_q     <= 1'b0;
      res_valid_q <= 1'b0;
      e_q <= '0;  it_q <= '0;  v_q <= '0;  s_q <= '0;
      chk_q <= 1'b0;  found_q <= 1'b0;
      seen_q <= '0;  vis_q <= '0;
    end else begin
      res_valid_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (cmd_valid_i) begin
            res_q <= '{status: ST_OK, distance: 32'd0, reachable: 1'b0};
            res_valid_q <= 1'b1;
            case (cmd_i.op)
              OP_ADD: begin
                if (edge_cnt_q == ECW'(MAX_EDGES)) begin
                  res_q.status <= ST_FULL;
                end else begin
                  edge_cnt_q <= edge_cnt_q + 1'b1;
                  valid_q <= 1'b0;
                  cycle_q <= 1'b0;
                end
              end
              OP_COMPUTE: begin
                res_valid_q <= 1'b0;
                v_q <= '0;
                state_q <= S_PINIT;
              end
              OP_QUERY: begin
                if (cycle_q) begin
                  res_q.status <= ST_NEG_CYCLE;
                end else if (!valid_q) begin
                  res_q.status <= ST_NOT_READY;
                end else if (in_range(cmd_i.src, vc_i) && in_range(cmd_i.dst, vc_i)) begin
                  res_valid_q <= 1'b0;
                  state_q <= S_QRY;
                end
              end
              OP_CLEAR: begin
                edge_cnt_q <= '0;
                valid_q <= 1'b0;
                cycle_q <= 1'b0;
              end
              default: ;
            endcase
          end
        end
        S_QRY: begin
          res_q <= '{status: ST_OK, distance: dist_rd[31:0], reachable: dist_rd[32]};
          res_valid_q <= 1'b1;
          state_q <= S_IDLE;
        end
        S_PINIT: begin
          v_q <= v_q + 1'b1;
          if (v_q == vc_i - 1'b1) begin
            it_q <= '0;
            e_q <= '0;
            chk_q <= 1'b0;
            state_q <= S_BF_RD;
          end
        end
        S_BF_RD: begin
          if (e_q == edge_cnt_q) begin
            e_q <= '0;
            if (chk_q) begin
              s_q <= '0;
              state_q <= S_DJ_INIT;
            end else if (it_q == vc_i - 1'b1) begin
              chk_q <= 1'b1;
            end else begin
              it_q <= it_q + 1'b1;
            end
          end else begin
            state_q <= S_BF_E;
          end
        end
        S_BF_E: begin
          edst_q <= VW'(er_dst);
          ew_q <= er_w;
          if (er_use) begin
            state_q <= S_BF_PS;
          end else begin
            e_q <= e_q + 1'b1;
            state_q <= S_BF_RD;
          end
        end
        S_BF_PS: begin
          acc_q <= sum;
          state_q <= S_BF_PD;
        end
        S_BF_PD: begin
          e_q <= e_q + 1'b1;
          state_q <= S_BF_RD;
          if (lt && chk_q) begin
            cycle_q <= 1'b1;
            valid_q <= 1'b0;
            res_q <= '{status: ST_NEG_CYCLE, distance: 32'd0, reachable: 1'b0};
            res_valid_q <= 1'b1;
            state_q <= S_IDLE;
          end
        end
        S_DJ_INIT: begin
          seen_q <= '0;
          seen_q[s_idx] <= 1'b1;
          vis_q <= '0;
          state_q <= S_DJ_PS;
        end
        S_DJ_PS: begin
          pots_q <= pot_x;
          v_q <= '0;
          found_q <= 1'b0;
          state_q <= S_SEL_RD;
        end
        S_SEL_RD: begin
          if (v_q == vc_i) begin
            state_q <= S_SEL_END;
          end else if (seen_q[v_idx] && !vis_q[v_idx]) begin
            state_q <= S_SEL_CMP;
          end else begin
            v_q <= v_q + 1'b1;
          end
        end
        S_SEL_CMP: begin
          // Strict less-than keeps the lowest index on ties.
          if (!found_q || lt) begin
            best_q <= v_idx;
            bestd_q <= d_x;
            found_q <= 1'b1;
          end
          v_q <= v_q + 1'b1;
          state_q <= S_SEL_RD;
        end
        S_SEL_END: begin
          if (found_q) begin
            vis_q[best_q] <= 1'b1;
            state_q <= S_DJ_PB;
          end else begin
            v_q <= '0;
            state_q <= S_FN_RD;
          end
        end
        S_DJ_PB: begin
          dbp_q <= sum;
          e_q <= '0;
          state_q <= S_RX_RD;
        end
        S_RX_RD: begin
          if (e_q == edge_cnt_q) begin
            v_q <= '0;
            found_q <= 1'b0;
            state_q <= S_SEL_RD;
          end else begin
            state_q <= S_RX_E;
          end
        end
        S_RX_E: begin
          edst_q <= VW'(er_dst);
          acc_q <= sum;
          if (er_use && VW'(er_src) == best_q) begin
            state_q <= S_RX_PT;
          end else begin
            e_q <= e_q + 1'b1;
            state_q <= S_RX_RD;
          end
        end
        S_RX_PT: begin
          acc_q <= sum;
          state_q <= S_RX_CMP;
        end
        S_RX_CMP: begin
          if (!seen_q[edst_q] || lt) begin
            seen_q[edst_q] <= 1'b1;
          end
          e_q <= e_q + 1'b1;
          state_q <= S_RX_RD;
        end
        S_FN_RD: begin
          if (v_q == vc_i) begin
            if (s_q == vc_i - 1'b1) begin
              valid_q <= 1'b1;
              cycle_q <= 1'b0;
              res_q <= '{status: ST_OK, distance: 32'd0, reachable: 1'b0};
              res_valid_q <= 1'b1;
              state_q <= S_IDLE;
            end else begin
              s_q <= s_q + 1'b1;
              state_q <= S_DJ_INIT;
            end
          end else begin
            state_q <= S_FN_A;
          end
        end
        S_FN_A: begin
          acc_q <= sum;
          state_q <= S_FN_B;
        end
        S_FN_B: begin
          acc_q <= sum;
          state_q <= S_FN_W;
        end
        S_FN_W: begin
          v_q <= v_q + 1'b1;
          state_q <= S_FN_RD;
        end
        default: state_q <= S_IDLE;
      endcase
      if (cfg_we_i) begin
        valid_q <= 1'b0;
        cycle_q <= 1'b0;
      end
    end
  end

  assign ready_o     = (state_q == S_IDLE) && !res_valid_q;
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  `APSP_ASSERT_IMP(a_cnt_bound, 1'b1, edge_cnt_q <= ECW'(MAX_EDGES), "edge count overflow")
  `APSP_ASSERT_IMP(a_flags_excl, 1'b1, !(cycle_q && valid_q), "cycle and valid both set")
  `APSP_ASSERT_IMP(a_res_idle, res_valid_q, state_q == S_IDLE, "result outside idle")
  `APSP_ASSERT_NXT(a_neg_res, res_valid_q && res_q.status == ST_NEG_CYCLE && !cfg_we_i
                   && $past(state_q) == S_BF_PD, cycle_q, "negative cycle not flagged")

endmodule

FILE: sv/all_pairs_shortest_path_top.sv
// Edge add, clear and rejected queries: the core gives the result in the cycle after the
// transaction, then it is registered at the output; a stored query first passes a memory read.
// Compute walks V vertices and E stored edges in turn through the single shared adder
// and the memories, each with one write port and one registered read port.
// Outside a compute, the input takes no new transaction until the core has issued the last result.
// Asynchronous active-low reset empties the edge store and drops all results.
`include "all_pairs_shortest_path_top_assert.svh"

module all_pairs_shortest_path_top import apsp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // src_vertex[3:0], dst_vertex[7:4], edge_weight[23:8]
  input  logic [1:0]  s_axis_tuser,   // op[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // distance[31:0]
  output logic [2:0]  m_axis_tuser,   // status[1:0], reachable[2]
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [4:0]  cfg_data_i      // vertex_count
);

  // Vertex count register; writes are clamped into the supported range.
  logic [VCW-1:0] vc_q;
  logic           cfg_we;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vc_q <= VCW'(MAX_VERTICES);
    end else if (cfg_we) begin
      if (cfg_data_i == 5'd0) begin
        vc_q <= VCW'(1);
      end else if (32'(cfg_data_i) > MAX_VERTICES) begin
        vc_q <= VCW'(MAX_VERTICES);
      end else begin
        vc_q <= VCW'(cfg_data_i);
      end
    end
  end

  // Command decode from the slave stream.
  cmd_t cmd;
  logic core_ready, res_valid, in_fire;
  res_t res;

  assign cmd.op     = op_e'(s_axis_tuser);
  assign cmd.src    = s_axis_tdata[3:0];
  assign cmd.dst    = s_axis_tdata[7:4];
  assign cmd.weight = s_axis_tdata[23:8];

  // The output register is free or draining, so the coming result has a place to land.
  logic out_valid_q;
  res_t out_q;

  assign s_axis_tready = core_ready && (!out_valid_q || m_axis_tready);
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  apsp_core u_core (
    .clk_i,
    .rst_ni,
    .cmd_valid_i (in_fire),
    .cmd_i       (cmd),
    .vc_i        (vc_q),
    .cfg_we_i    (cfg_we),
    .ready_o     (core_ready),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  // Result register toward the master stream.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_valid) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q.distance;
  assign m_axis_tuser  = {out_q.reachable, out_q.status};

  `APSP_ASSERT_IMP(a_no_overrun, res_valid, !out_valid_q || m_axis_tready, "result overrun")
  `APSP_ASSERT_NXT(a_valid_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid, "result dropped")
  `APSP_ASSERT_NXT(a_data_hold, m_axis_tvalid && !m_axis_tready, $stable(out_q), "result changed")

endmodule
